### src/sachc_pkg.sv
// Shared types and constants for the set-associative hit counter.
// No dependencies; imported by the controller, the datapath and the top level.
package sachc_pkg;

    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 32;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic clear_step;   // clear valid bits of one set
        logic lookup;       // latch address, read the set
        logic commit;       // compare, write back, update totals and result
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;   // clearing the last set this cycle
    } dp_status_t;

endpackage

### src/set_assoc_cache_hit_counter_unit.sv
// Set-associative tag cache with FIFO replacement that reports, for each address word,
// whether it hit plus saturating running hit and miss totals. On acceptance of a word
// the set's row is read from the tag memory into a register; then all ways are
// compared, the shifted row is written back on a miss and the result register is
// loaded; a result still waiting at the output holds that compare step. After reset a
// clearing pass over all 2^(LINE_COUNT_LOG2 - min(WAY_COUNT_LOG2, LINE_COUNT_LOG2)) sets
// (16 by default) zeroes the valid bits one set per cycle; in_ready stays low until then.
// Top level: joins sachc_ctrl and sachc_datapath; depends on sachc_pkg.
module set_assoc_cache_hit_counter_unit
    import sachc_pkg::*;
#(
    parameter int LINE_COUNT_LOG2  = 6,
    parameter int BLOCK_BYTES_LOG2 = 4,
    parameter int WAY_COUNT_LOG2   = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [ADDR_W-1:0]  address,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic [COUNT_W-1:0] hit_count,
    output logic [COUNT_W-1:0] miss_count
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    sachc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    sachc_datapath #(
        .LINE_COUNT_LOG2  (LINE_COUNT_LOG2),
        .BLOCK_BYTES_LOG2 (BLOCK_BYTES_LOG2),
        .WAY_COUNT_LOG2   (WAY_COUNT_LOG2)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .address    (address),
        .hit        (hit),
        .hit_count  (hit_count),
        .miss_count (miss_count)
    );

endmodule

### src/sachc_ctrl.sv
// Controller state machine for the set-associative hit counter.
// Depends on sachc_pkg; drives the datapath through ctrl_cmd_t.
module sachc_ctrl
    import sachc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.lookup = in_valid;
            end
            ST_LOOK:
            begin
                cmd.commit = slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // an accepted word is looked up next cycle, no new word meanwhile
    a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_LOOK) && !in_ready)
        else $error("accepted word did not move to lookup");

    // a commit always presents a result on the next cycle
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("commit without result");

    // the clearing pass never overlaps with lookups or commits
    a_clear_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_step |-> !cmd.lookup && !cmd.commit && !in_ready)
        else $error("clearing overlaps traffic");

    // a commit never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !cmd.commit)
        else $error("pending result overwritten");

endmodule

### src/sachc_datapath.sv
// Datapath: per-set tag and valid memories, way compare, FIFO shift and totals.
// Depends on sachc_pkg; commanded by sachc_ctrl.
module sachc_datapath
    import sachc_pkg::*;
#(
    parameter int LINE_COUNT_LOG2  = 6,
    parameter int BLOCK_BYTES_LOG2 = 4,
    parameter int WAY_COUNT_LOG2   = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    output dp_status_t         status,
    input  logic [ADDR_W-1:0]  address,
    output logic               hit,
    output logic [COUNT_W-1:0] hit_count,
    output logic [COUNT_W-1:0] miss_count
);

    localparam int WAYS_LOG2 = (WAY_COUNT_LOG2 > LINE_COUNT_LOG2) ? LINE_COUNT_LOG2
                                                                  : WAY_COUNT_LOG2;
    localparam int WAYS      = 1 << WAYS_LOG2;
    localparam int SET_BITS  = LINE_COUNT_LOG2 - WAYS_LOG2;
    localparam int SETS      = 1 << SET_BITS;
    localparam int SET_AW    = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int TAG_SHIFT = BLOCK_BYTES_LOG2 + SET_BITS;
    localparam int TAG_W     = ADDR_W - TAG_SHIFT;

    localparam logic [SET_AW-1:0] SET_LAST = SET_AW'(SETS - 1);

    typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;

    tag_row_t              tag_mem [SETS];
    logic [WAYS-1:0]       vld_mem [SETS];

    logic [ADDR_W-1:0]     addr_shifted;
    logic [SET_AW-1:0]     set_idx;
    logic [SET_AW-1:0]     set_reg;
    logic [TAG_W-1:0]      tag_reg;
    logic [SET_AW-1:0]     clr_idx_reg;
    tag_row_t              rd_tags_reg;
    logic [WAYS-1:0]       rd_vld_reg;

    logic [WAYS-1:0]       way_match;
    logic                  lookup_hit;
    logic [WAYS:0][TAG_W-1:0] tags_ext;
    logic [WAYS:0]         vld_ext;
    tag_row_t              new_tags;
    logic [WAYS-1:0]       new_vld;
    logic                  fill;
    logic                  vld_we;
    logic [SET_AW-1:0]     vld_waddr;
    logic [WAYS-1:0]       vld_wdata;

    logic                  hit_reg;
    logic [COUNT_W-1:0]    hit_total_reg;
    logic [COUNT_W-1:0]    miss_total_reg;

    assign addr_shifted = address >> BLOCK_BYTES_LOG2;
    assign set_idx      = addr_shifted[SET_AW-1:0] & SET_LAST;

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            set_reg     <= set_idx;
            tag_reg     <= address[ADDR_W-1 -: TAG_W];
            rd_tags_reg <= tag_mem[set_idx];
            rd_vld_reg  <= vld_mem[set_idx];
        end
    end

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            way_match[w] = rd_vld_reg[w] && (rd_tags_reg[w] == tag_reg);
        end
    end

    assign lookup_hit = |way_match;

    // FIFO insert: each tag moves up one way, the last way's tag drops out, the new tag enters way 0
    assign tags_ext = {rd_tags_reg, tag_reg};
    assign vld_ext  = {rd_vld_reg, 1'b1};
    assign new_tags = tags_ext[WAYS-1:0];
    assign new_vld  = vld_ext[WAYS-1:0];
    assign fill     = cmd.commit && !lookup_hit;

    always_ff @(posedge clk)
    begin
        if (fill)
        begin
            tag_mem[set_reg] <= new_tags;
        end
    end

    assign vld_we    = cmd.clear_step || fill;
    assign vld_waddr = cmd.clear_step ? clr_idx_reg : set_reg;
    assign vld_wdata = cmd.clear_step ? '0 : new_vld;

    always_ff @(posedge clk)
    begin
        if (vld_we)
        begin
            vld_mem[vld_waddr] <= vld_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_idx_reg <= (clr_idx_reg == SET_LAST) ? '0 : clr_idx_reg + 1'b1;
        end
    end

    assign status.clear_last = cmd.clear_step && (clr_idx_reg == SET_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_total_reg  <= '0;
            miss_total_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (lookup_hit)
            begin
                if (hit_total_reg != '1)
                begin
                    hit_total_reg <= hit_total_reg + 1'b1;
                end
            end
            else if (miss_total_reg != '1)
            begin
                miss_total_reg <= miss_total_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit_reg <= lookup_hit;
        end
    end

    assign hit        = hit_reg;
    assign hit_count  = hit_total_reg;
    assign miss_count = miss_total_reg;

endmodule
